// ===== hdl/gtd_pkg.sv =====
package gtd_pkg;

  // fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int COEFF_W    = 16;
  localparam int WLEN_W     = 13;
  localparam int MAG_W      = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WLEN  = 2'd2;

  // register reset values
  localparam logic signed [COEFF_W-1:0] COEFF_RST = 16'sd27980;
  localparam logic signed [COEFF_W-1:0] SINE_RST  = 16'sd17056;
  localparam logic [WLEN_W-1:0]         WLEN_RST  = 13'd205;

  // saturation limit of the magnitude
  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_REC_MUL,
    S_REC_ADD,
    S_RE_MUL,
    S_RE_SUB,
    S_IM_CAP,
    S_SQ,
    S_SQ_TAIL,
    S_SQRT,
    S_DONE
  } ctrl_state_t;

  // operand pairs of the shared signed multiplier
  typedef enum logic [1:0] {
    MUL_REC,
    MUL_RE,
    MUL_IM
  } mul_sel_t;

  // partial products of the two squares (low and high halves)
  localparam int PP_SEL_W = 3;
  typedef enum logic [PP_SEL_W-1:0] {
    PP_RE_LL,
    PP_RE_LH,
    PP_RE_HH,
    PP_IM_LL,
    PP_IM_LH,
    PP_IM_HH
  } pp_sel_t;

  // commands from sequencer to datapath
  typedef struct packed {
    logic     load_sample;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     rec_upd;
    logic     re_cap;
    logic     im_cap;
    logic     sq_issue;
    pp_sel_t  pp_sel;
    logic     sqrt_step;
    logic     out_load;
  } cmd_t;

  // status from datapath to sequencer
  typedef struct packed {
    logic win_end;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/goertzel_tone_detector_unit.sv =====
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  in_sample (16b signed)
// out_      output     out_valid/out_stall  out_magnitude (40b unsigned)
// cfg_      input      cfg_wr_en            cfg_index (2b), cfg_data (16b)
//
// a sample that does not close its window passes through accept, multiply and add
// a window-closing sample then also forms the real and imaginary terms, their squares and
// a bit-serial square root of ROOT_W = 2*floor((ACC_WIDTH+3)/2) bits
// reset is synchronous, active low; the configuration registers return to their stated values
// a stalled result sits in the output register while the next samples are taken
module goertzel_tone_detector_unit import gtd_pkg::*; #(
  parameter int MAX_WINDOW = 4096,
  parameter int ACC_WIDTH  = 40
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [MAG_W-1:0]           out_magnitude,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  localparam int HALF_W = (ACC_WIDTH + 3) / 2;
  localparam int ROOT_W = 2 * HALF_W;

  cmd_t    cmd;
  status_t status;

  // sequencer
  gtd_ctrl #(
    .ROOT_W (ROOT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and storage
  gtd_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_sample     (in_sample),
    .cmd           (cmd),
    .status        (status),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_magnitude (out_magnitude)
  );

endmodule

// ===== hdl/gtd_ctrl.sv =====
module gtd_ctrl import gtd_pkg::*; #(
  parameter int ROOT_W = 42
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam int STEP_W = $clog2(ROOT_W);

  ctrl_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    cmd         = '0;
    cmd.mul_sel = MUL_REC;
    cmd.pp_sel  = PP_RE_LL;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_sample = 1'b1;
          state_nxt       = S_REC_MUL;
        end
      end
      S_REC_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_REC;
        state_nxt   = S_REC_ADD;
      end
      S_REC_ADD: begin
        cmd.rec_upd = 1'b1;
        state_nxt   = status.win_end ? S_RE_MUL : S_IDLE;
      end
      S_RE_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RE;
        state_nxt   = S_RE_SUB;
      end
      S_RE_SUB: begin
        cmd.re_cap  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_IM;
        state_nxt   = S_IM_CAP;
      end
      S_IM_CAP: begin
        cmd.im_cap = 1'b1;
        step_nxt   = '0;
        state_nxt  = S_SQ;
      end
      S_SQ: begin
        cmd.sq_issue = 1'b1;
        cmd.pp_sel   = pp_sel_t'(step_r[PP_SEL_W-1:0]);
        if (step_r[PP_SEL_W-1:0] == PP_IM_HH) begin
          step_nxt  = '0;
          state_nxt = S_SQ_TAIL;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_SQ_TAIL: begin
        step_nxt  = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step_r == STEP_W'(ROOT_W - 1)) begin
          step_nxt  = '0;
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  // magnitude work starts only after a sample that closed its window
  a_win_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_RE_MUL) |-> $past(status.win_end))
    else $error("magnitude started without a window end");

  // a result is only loaded into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("output register overwritten");

endmodule

// ===== hdl/gtd_datapath.sv =====
module gtd_datapath import gtd_pkg::*; #(
  parameter int MAX_WINDOW = 4096,
  parameter int ACC_WIDTH  = 40
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  cmd_t                       cmd,
  output status_t                    status,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [MAG_W-1:0]           out_magnitude
);

  localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W   = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
  localparam int PROD_W  = ACC_WIDTH + COEFF_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int HALF_W  = (ACC_WIDTH + 3) / 2;
  localparam int ABS_W   = 2 * HALF_W;
  localparam int PWR_W   = 4 * HALF_W;
  localparam int ROOT_W  = 2 * HALF_W;
  localparam int REM_W   = ROOT_W + 3;
  localparam int EXT_W   = 64;

  localparam logic signed [PROD_W-1:0] HALF14 = PROD_W'(1) << 13;
  localparam logic signed [PROD_W-1:0] HALF15 = PROD_W'(1) << 14;
  localparam logic signed [ACC_WIDTH-1:0] ACC_HI = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_LO = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic signed [COEFF_W-1:0]   coeff_r, sine_r;
  logic [WLEN_W-1:0]           wlen_r;
  logic signed [SAMPLE_W-1:0]  sample_r;
  logic signed [ACC_WIDTH-1:0] acc_prev_r, acc_prev2_r, acc_sat;
  logic [CNT_W-1:0]            cnt_r;
  logic [CMP_W-1:0]            wlen_ext, eff_len, cnt_inc;
  logic signed [ACC_WIDTH-1:0] mul_a;
  logic signed [COEFF_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]    prod_nxt, prod_r, prod_rnd14, prod_rnd15;
  logic signed [SUM_W-1:0]     q_sum, re_val;
  logic [SUM_W-1:0]            re_mag;
  logic [PROD_W-1:0]           im_mag;
  logic [ABS_W-1:0]            abs_re_r, abs_im_r;
  logic [HALF_W-1:0]           pp_x, pp_y;
  logic [2*HALF_W-1:0]         sq_prod_r;
  pp_sel_t                     sq_sel_r;
  logic                        sq_pend_r;
  logic [PWR_W-1:0]            pwr_r, pp_term;
  logic [REM_W-1:0]            rem_r, rem_sh, trial;
  logic [ROOT_W-1:0]           root_r;
  logic                        root_ge;
  logic [EXT_W-1:0]            root_ext;
  logic [MAG_W-1:0]            mag_sat;
  logic                        out_valid_r;
  logic [MAG_W-1:0]            out_mag_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= COEFF_RST;
      sine_r  <= SINE_RST;
      wlen_r  <= WLEN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_COEFF: coeff_r <= cfg_data;
        CFG_SINE:  sine_r  <= cfg_data;
        CFG_WLEN:  wlen_r  <= cfg_data[WLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // window length clamped to one up to the maximum
  always_comb begin
    wlen_ext = CMP_W'(wlen_r);
    if (wlen_r == '0) begin
      eff_len = CMP_W'(1);
    end else if (wlen_ext > CMP_W'(MAX_WINDOW)) begin
      eff_len = CMP_W'(MAX_WINDOW);
    end else begin
      eff_len = wlen_ext;
    end
    cnt_inc = CMP_W'(cnt_r) + CMP_W'(1);
  end

  assign status.win_end  = (cnt_inc >= eff_len);
  assign status.out_free = !out_valid_r || !out_stall;

  // shared signed multiplier, operands picked by the sequencer
  always_comb begin
    case (cmd.mul_sel)
      MUL_REC: begin
        mul_a = acc_prev_r;
        mul_b = coeff_r;
      end
      MUL_RE: begin
        mul_a = acc_prev2_r;
        mul_b = coeff_r;
      end
      MUL_IM: begin
        mul_a = acc_prev2_r;
        mul_b = sine_r;
      end
      default: begin
        mul_a = acc_prev_r;
        mul_b = coeff_r;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.load_sample) begin
      sample_r <= in_sample;
    end
  end

  // round half up, recurrence sum and saturation, real term and absolute values
  always_comb begin
    prod_rnd14 = (prod_r + HALF14) >>> 14;
    prod_rnd15 = (prod_r + HALF15) >>> 15;
    q_sum      = prod_rnd14 - acc_prev2_r + sample_r;
    if (q_sum > ACC_HI) begin
      acc_sat = ACC_HI;
    end else if (q_sum < ACC_LO) begin
      acc_sat = ACC_LO;
    end else begin
      acc_sat = q_sum[ACC_WIDTH-1:0];
    end
    re_val = acc_prev_r - prod_rnd15;
    re_mag = re_val[SUM_W-1] ? SUM_W'(-re_val) : SUM_W'(re_val);
    im_mag = prod_rnd15[PROD_W-1] ? PROD_W'(-prod_rnd15) : PROD_W'(prod_rnd15);
  end

  // accumulators and sample count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_prev_r  <= '0;
      acc_prev2_r <= '0;
      cnt_r       <= '0;
    end else if (cmd.im_cap) begin
      acc_prev_r  <= '0;
      acc_prev2_r <= '0;
      cnt_r       <= '0;
    end else if (cmd.rec_upd) begin
      acc_prev2_r <= acc_prev_r;
      acc_prev_r  <= acc_sat;
      cnt_r       <= cnt_inc[CNT_W-1:0];
    end
  end

  // magnitudes of the real and imaginary terms
  always_ff @(posedge clk) begin
    if (cmd.re_cap) begin
      abs_re_r <= re_mag[ABS_W-1:0];
    end
    if (cmd.im_cap) begin
      abs_im_r <= im_mag[ABS_W-1:0];
    end
  end

  // half-width partial products of the two squares
  always_comb begin
    case (cmd.pp_sel)
      PP_RE_LL: begin
        pp_x = abs_re_r[HALF_W-1:0];
        pp_y = abs_re_r[HALF_W-1:0];
      end
      PP_RE_LH: begin
        pp_x = abs_re_r[HALF_W-1:0];
        pp_y = abs_re_r[ABS_W-1:HALF_W];
      end
      PP_RE_HH: begin
        pp_x = abs_re_r[ABS_W-1:HALF_W];
        pp_y = abs_re_r[ABS_W-1:HALF_W];
      end
      PP_IM_LL: begin
        pp_x = abs_im_r[HALF_W-1:0];
        pp_y = abs_im_r[HALF_W-1:0];
      end
      PP_IM_LH: begin
        pp_x = abs_im_r[HALF_W-1:0];
        pp_y = abs_im_r[ABS_W-1:HALF_W];
      end
      PP_IM_HH: begin
        pp_x = abs_im_r[ABS_W-1:HALF_W];
        pp_y = abs_im_r[ABS_W-1:HALF_W];
      end
      default: begin
        pp_x = '0;
        pp_y = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_pend_r <= 1'b0;
    end else begin
      sq_pend_r <= cmd.sq_issue;
    end
    if (cmd.sq_issue) begin
      sq_prod_r <= pp_x * pp_y;
      sq_sel_r  <= cmd.pp_sel;
    end
  end

  // place each partial product; cross terms count twice
  always_comb begin
    case (sq_sel_r)
      PP_RE_LL, PP_IM_LL: pp_term = PWR_W'(sq_prod_r);
      PP_RE_LH, PP_IM_LH: pp_term = PWR_W'(sq_prod_r) << (HALF_W + 1);
      PP_RE_HH, PP_IM_HH: pp_term = PWR_W'(sq_prod_r) << (2 * HALF_W);
      default:            pp_term = '0;
    endcase
  end

  // square root step: two power bits in, one root bit out
  always_comb begin
    rem_sh   = {rem_r[REM_W-3:0], pwr_r[PWR_W-1 -: 2]};
    trial    = REM_W'({root_r, 2'b01});
    root_ge  = (rem_sh >= trial);
    root_ext = EXT_W'(root_r);
    mag_sat  = (root_ext > EXT_W'(MAG_MAX)) ? MAG_MAX : root_ext[MAG_W-1:0];
  end

  // root registers and power accumulator, the latter later shifted out by the root unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.im_cap) begin
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      rem_r  <= root_ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], root_ge};
    end
    if (cmd.im_cap) begin
      pwr_r <= '0;
    end else if (sq_pend_r) begin
      pwr_r <= pwr_r + pp_term;
    end else if (cmd.sqrt_step) begin
      pwr_r <= pwr_r << 2;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_mag_r <= mag_sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_magnitude = out_mag_r;

  // the root remainder never exceeds twice the partial root
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= REM_W'({root_r, 1'b0}))
    else $error("square root remainder out of range");

  // the sample count stays within the longest window
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_WINDOW))
    else $error("sample count beyond window");

  // a result appears only after the sequencer loaded one
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.out_load))
    else $error("result without load");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import gtd_pkg::*;

  localparam int ACC_W         = 40;
  localparam int MAX_WIN       = 4096;
  // wait after a window-closing sample: the magnitude steps and the serial root, plus a margin
  localparam int SETTLE_CYCLES = 14 + 2 * ((ACC_W + 3) / 2) + 16;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int LONG_RUN      = 300;
  localparam int RANDOM_ITEMS  = 925;

  logic                       clk;
  logic                       rst_n         = 1'b0;
  logic                       in_valid      = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample     = '0;
  logic                       out_valid;
  logic                       out_stall     = 1'b0;
  logic [MAG_W-1:0]           out_magnitude;
  logic                       cfg_wr_en     = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index     = CFG_COEFF;
  logic [CFG_DATA_W-1:0]      cfg_data      = '0;

  // predictor copy of registers and window state
  logic signed [COEFF_W-1:0] coeff_reg = COEFF_RST;
  logic signed [COEFF_W-1:0] sine_reg  = SINE_RST;
  logic [WLEN_W-1:0]         wlen_reg  = WLEN_RST;
  longint                    acc_prev  = 0;
  longint                    acc_prev2 = 0;
  int                        win_count = 0;

  // magnitudes still owed by the block, oldest first
  logic [MAG_W-1:0] magnitude_q[$];
  logic [MAG_W-1:0] exp_mag;

  bit gaps_on        = 1'b1;
  int err_count      = 0;
  int cycle_count    = 0;
  int samples_sent   = 0;
  int windows_closed = 0;
  int reg_writes     = 0;

  goertzel_tone_detector_unit #(
    .MAX_WINDOW(MAX_WIN),
    .ACC_WIDTH (ACC_W)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_magnitude(out_magnitude),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // rounding shift, halves go towards +infinity
  function automatic longint round_sh(input longint v, input int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clamp_acc(input longint v);
    longint hi;
    hi = (longint'(1) << (ACC_W - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // floor root of real^2 + imag^2 at the window end
  function automatic logic [MAG_W-1:0] bin_magnitude();
    longint       re;
    longint       im;
    logic [63:0]  re_abs;
    logic [63:0]  im_abs;
    logic [63:0]  root;
    logic [63:0]  cand;
    logic [127:0] power;
    logic [127:0] trial;
    int           b;
    re     = acc_prev - round_sh(acc_prev2 * longint'(coeff_reg), 15);
    im     = round_sh(acc_prev2 * longint'(sine_reg), 15);
    re_abs = (re < 0) ? -re : re;
    im_abs = (im < 0) ? -im : im;
    power  = {64'd0, re_abs} * {64'd0, re_abs} + {64'd0, im_abs} * {64'd0, im_abs};
    root   = '0;
    for (b = ACC_W + 1; b >= 0; b--) begin
      cand  = root | (64'd1 << b);
      trial = {64'd0, cand} * {64'd0, cand};
      if (trial <= power) root = cand;
    end
    if (root > MAG_MAX) return MAG_MAX;
    return root[MAG_W-1:0];
  endfunction

  // one recurrence step; returns 1 when the sample closes a window
  function automatic bit goertzel_step(input logic signed [SAMPLE_W-1:0] s,
                                       output logic [MAG_W-1:0] mag);
    longint q0;
    int     len;
    q0  = round_sh(longint'(coeff_reg) * acc_prev, 14) - acc_prev2 + longint'(s);
    len = int'(wlen_reg);
    if (len == 0) len = 1;
    if (len > MAX_WIN) len = MAX_WIN;
    acc_prev2 = acc_prev;
    acc_prev  = clamp_acc(q0);
    win_count++;
    mag = '0;
    if (win_count < len) return 1'b0;
    mag       = bin_magnitude();
    acc_prev  = 0;
    acc_prev2 = 0;
    win_count = 0;
    return 1'b1;
  endfunction

  // mostly uniform, sometimes a full-scale or near-zero word
  function automatic logic [15:0] pick_word();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'h0000;
          3:       return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // one sample transaction, predictor updated on acceptance
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    logic [MAG_W-1:0] mag;
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 35) begin
      in_valid  <= 1'b0;
      in_sample <= SAMPLE_W'($urandom);
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
    if (goertzel_step(s, mag)) magnitude_q.push_back(mag);
  endtask

  // write all three registers once the block has gone quiet
  task automatic apply_config(input logic [CFG_DATA_W-1:0] c,
                              input logic [CFG_DATA_W-1:0] s,
                              input logic [CFG_DATA_W-1:0] w);
    @(negedge clk);
    in_valid <= 1'b0;
    while (magnitude_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_COEFF;
    cfg_data  <= c;
    @(negedge clk);
    cfg_index <= CFG_SINE;
    cfg_data  <= s;
    @(negedge clk);
    cfg_index <= CFG_WLEN;
    cfg_data  <= w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    coeff_reg  = c;
    sine_reg   = s;
    wlen_reg   = w[WLEN_W-1:0];
    reg_writes += 3;
  endtask

  // register values straight out of reset, one full window
  task automatic test_default_window();
    repeat (int'(WLEN_RST)) send_sample(pick_word());
  endtask

  // window length zero acts as one: every sample closes a window
  task automatic test_single_sample_windows();
    apply_config(16'd16384, 16'hC000, 16'd0);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
  endtask

  // extreme coefficients, and window bits above the field ignored
  task automatic test_full_scale_windows();
    apply_config(16'h7FFF, 16'h7FFF, 16'd4);
    repeat (4) send_sample(16'sh7FFF);
    apply_config(16'h8000, 16'h8000, 16'hE003);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
  endtask

  // shorter window written part way through: the next sample closes it
  task automatic test_write_mid_window();
    apply_config(16'd27980, 16'd17056, 16'd10);
    send_sample(16'sd1200);
    send_sample(-16'sd3000);
    send_sample(16'sd32000);
    send_sample(-16'sd17);
    apply_config(16'hD120, 16'd9000, 16'd2);
    send_sample(16'sd500);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
  endtask

  // oversize length keeps the window open through a run with no idling,
  // then a short length closes it on the next sample
  task automatic test_longest_window();
    int k;
    apply_config(16'h8000, 16'h7FFF, 16'h1FFF);
    gaps_on = 1'b0;
    for (k = 0; k < LONG_RUN; k++) send_sample(k[0] ? 16'sh8001 : 16'sh7FFF);
    gaps_on = 1'b1;
    apply_config(16'h8000, 16'h7FFF, 16'd2);
    send_sample(16'sh7FFF);
  endtask

  // random settings and sample runs; partial windows carry across writes
  task automatic test_random_windows();
    int                    sent;
    int                    wl;
    int                    n;
    logic [CFG_DATA_W-1:0] wdata;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(19))
        0:       wl = 0;
        1, 2:    wl = $urandom_range(13, 64);
        3:       wl = $urandom_range(65, 300);
        default: wl = $urandom_range(1, 12);
      endcase
      wdata = CFG_DATA_W'(wl);
      if ($urandom_range(3) == 0) wdata[CFG_DATA_W-1:WLEN_W] = 3'($urandom);
      apply_config(pick_word(), pick_word(), wdata);
      n = $urandom_range(1, 3 * ((wl == 0) ? 1 : wl) + 2);
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      repeat (n) send_sample(pick_word());
      sent += n;
    end
  endtask

  // idle pattern of the result side
  always @(negedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 35);
  end

  // compare each result transaction with the oldest owed magnitude
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (magnitude_q.size() == 0) begin
        $display("%0t: unexpected magnitude, expected none, actual %0d",
                 $time, out_magnitude);
        err_count++;
      end else begin
        exp_mag = magnitude_q.pop_front();
        windows_closed++;
        if (out_magnitude !== exp_mag) begin
          $display("%0t: magnitude mismatch, expected %0d, actual %0d",
                   $time, exp_mag, out_magnitude);
          err_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d magnitudes outstanding",
               $time, cycle_count, magnitude_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_window();
    test_single_sample_windows();
    test_full_scale_windows();
    test_write_mid_window();
    test_longest_window();
    test_random_windows();

    // drain and let the block settle
    @(negedge clk);
    in_valid <= 1'b0;
    while (magnitude_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d samples, %0d closed windows, %0d register writes",
             samples_sent, windows_closed, reg_writes);
    $display("window lengths 0 to 300, an oversize length held open, %0d errors",
             err_count);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
